### design/sdfw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdfw_pkg;

  localparam int EXT_FRAME_BITS = 24;
  localparam int INT_FRAME_BITS = 8;

  // Frame shift register covers the longer of the two frames
  localparam int SHIFT_W = (EXT_FRAME_BITS > INT_FRAME_BITS) ? EXT_FRAME_BITS : INT_FRAME_BITS;
  localparam int BIDX_W  = $clog2(SHIFT_W + 1);
  localparam int IDX_W   = $clog2(SHIFT_W);

  localparam int          DATA_W       = 16;
  localparam int          EXT_SHIFT    = 6;
  localparam logic [31:0] EXT_WORD_MSK = 32'h003F_FFC0;

  localparam logic FUNC_EXT = 1'b0;
  localparam logic FUNC_INT = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_OFF    = 2'd2,
    ST_BUSY   = 2'd3
  } status_t;

  typedef struct packed {
    status_t start_status;
    logic    busy_res;
    logic    cs_aux;
    logic    cs_ext;
    logic    cs_int;
    logic    mosi;
    logic    sck;
    logic    done_res;
  } result_t;

endpackage

`default_nettype wire

### design/sdfw_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sdfw_core
  import sdfw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              power_on,
  input  wire logic              start_req,
  input  wire logic              func,
  input  wire logic [DATA_W-1:0] data,
  output result_t                res
);

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_DATA  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  logic               active_r,   active_nxt;
  logic               mode_r,     mode_nxt;
  phase_t             phase_r,    phase_nxt;
  logic [BIDX_W-1:0]  bit_idx_r,  bit_idx_nxt;
  logic [SHIFT_W-1:0] shift_r,    shift_nxt;
  logic               sck_r,      sck_nxt;
  logic               mosi_r,     mosi_nxt;
  logic               cs_int_r,   cs_int_nxt;
  logic               cs_ext_r,   cs_ext_nxt;

  logic [BIDX_W-1:0]  nbits;
  logic [BIDX_W-1:0]  bit_pos;
  logic [SHIFT_W-1:0] ext_word;
  logic [SHIFT_W-1:0] int_word;
  status_t            status;
  logic               done;

  assign nbits    = mode_r ? BIDX_W'(INT_FRAME_BITS) : BIDX_W'(EXT_FRAME_BITS);
  assign bit_pos  = nbits - BIDX_W'(1) - bit_idx_r;
  assign ext_word = SHIFT_W'(({16'b0, data} << EXT_SHIFT) & EXT_WORD_MSK);
  assign int_word = SHIFT_W'(data[7:0]);

  always_comb begin
    active_nxt  = active_r;
    mode_nxt    = mode_r;
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    sck_nxt     = sck_r;
    mosi_nxt    = mosi_r;
    cs_int_nxt  = cs_int_r;
    cs_ext_nxt  = cs_ext_r;
    status      = ST_NONE;
    done        = 1'b0;

    if (active_r) begin
      if (bit_idx_r >= nbits) begin
        // closing tick: deselect all and park the bus
        sck_nxt     = 1'b0;
        mosi_nxt    = 1'b0;
        cs_int_nxt  = 1'b1;
        cs_ext_nxt  = 1'b1;
        active_nxt  = 1'b0;
        phase_nxt   = PH_LEAD;
        bit_idx_nxt = '0;
        done        = 1'b1;
      end else begin
        case (phase_r)
          PH_DATA: begin
            mosi_nxt  = shift_r[bit_pos[IDX_W-1:0]];
            phase_nxt = PH_TRAIL;
          end
          PH_TRAIL: begin
            sck_nxt     = mode_r;
            phase_nxt   = PH_LEAD;
            bit_idx_nxt = bit_idx_r + BIDX_W'(1);
          end
          default: begin
            sck_nxt   = ~mode_r;
            phase_nxt = PH_DATA;
          end
        endcase
      end
      if (start_req) begin
        status = power_on ? ST_BUSY : ST_OFF;
      end
    end else if (start_req) begin
      if (!power_on) begin
        status = ST_OFF;
      end else begin
        status      = ST_ACCEPT;
        active_nxt  = 1'b1;
        mode_nxt    = func;
        phase_nxt   = PH_LEAD;
        bit_idx_nxt = '0;
        shift_nxt   = (func == FUNC_INT) ? int_word : ext_word;
        sck_nxt     = 1'b0;
        mosi_nxt    = 1'b0;
        cs_int_nxt  = (func == FUNC_INT) ? 1'b0 : 1'b1;
        cs_ext_nxt  = (func == FUNC_INT) ? 1'b1 : 1'b0;
      end
    end

    res.sck          = sck_nxt;
    res.mosi         = mosi_nxt;
    res.cs_int       = cs_int_nxt;
    res.cs_ext       = cs_ext_nxt;
    res.cs_aux       = 1'b1;
    res.busy_res     = active_nxt;
    res.start_status = status;
    res.done_res     = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      mode_r    <= 1'b0;
      phase_r   <= PH_LEAD;
      bit_idx_r <= '0;
      shift_r   <= '0;
      sck_r     <= 1'b0;
      mosi_r    <= 1'b0;
      cs_int_r  <= 1'b1;
      cs_ext_r  <= 1'b1;
    end else if (step) begin
      active_r  <= active_nxt;
      mode_r    <= mode_nxt;
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      sck_r     <= sck_nxt;
      mosi_r    <= mosi_nxt;
      cs_int_r  <= cs_int_nxt;
      cs_ext_r  <= cs_ext_nxt;
    end
  end

endmodule

`default_nettype wire

### design/sdfw_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module sdfw_out_reg
  import sdfw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res,
  input  wire logic    out_tready,
  output logic         out_tvalid,
  output logic [7:0]   out_tdata,
  output logic         out_tlast,
  output logic         free
);

  logic    valid_r;
  result_t res_r;

  // take a new result when empty or when the held one leaves this cycle
  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.done_res;
  assign out_tdata  = {res_r.start_status, res_r.busy_res, res_r.cs_aux,
                       res_r.cs_ext, res_r.cs_int, res_r.mosi, res_r.sck};

endmodule

`default_nettype wire

### design/serial_dac_frame_writer_top.sv
// Write-only serial master that drives SCK, MOSI and two active-low converter
// selects, one input request per waveform tick.
// Input channel: in_tuser carries start_req and func, in_tdata the 16-bit value.
// Each accepted request advances the frame sequencer by one tick and yields
// exactly one result: the pin levels for that tick plus start status, busy and
// a done flag (out_tlast) on the closing tick that deselects everything.
// Frame length: one setup tick, three ticks per bit, one closing tick
// (74 ticks for the external 24-bit frame, 26 for the internal 8-bit frame).
// The result is registered and valid in the cycle after input accept; throughput is
// one request per cycle while out_tready is high, set by the single output register.
// When the receiver stalls, the result is held and the input is stalled
// behind it; no tick is dropped or repeated.
// Reset (synchronous, active low) parks the bus: SCK and MOSI low, selects
// high, no frame running, detector power off.
// cfg_wr_en writes the detector power bit; starts are refused while it is low.
`timescale 1ns / 1ps
`default_nettype none

module serial_dac_frame_writer_top
  import sdfw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] data
  input  wire logic [1:0]  in_tuser,   // [0] start_req, [1] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] sck, [1] mosi, [2] cs_int, [3] cs_ext,
                                       // [4] cs_aux, [5] busy_res, [7:6] start_status
  output logic             out_tlast   // done_res
);

  logic    power_on_r;
  logic    free;
  logic    step;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r <= 1'b0;
    end else if (cfg_wr_en) begin
      power_on_r <= cfg_wr_data;
    end
  end

  assign in_tready = free;
  assign step      = in_tvalid && free;

  sdfw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .power_on  (power_on_r),
    .start_req (in_tuser[0]),
    .func      (in_tuser[1]),
    .data      (in_tdata),
    .res       (res)
  );

  sdfw_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .free       (free)
  );

endmodule

`default_nettype wire

### design/sdfw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdfw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // never select both converters, and keep the aux select high
  a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] || out_tdata[3]) && out_tdata[4])
    else $error("both selects low or aux select dropped");

  // closing tick parks the bus and ends the frame
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == 4'b1100 && !out_tdata[5])
    else $error("closing tick left bus active");

  // an accepted start opens a frame on exactly one converter
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] == 2'd1 |->
      out_tdata[5] && (out_tdata[2] != out_tdata[3]) && !out_tdata[0] && !out_tlast)
    else $error("accepted start without frame");

endmodule

bind serial_dac_frame_writer_top sdfw_checker u_sdfw_checker (.*);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sdfw_pkg::*;

  localparam int STALL_LIMIT = 5000;  // cycles without any handshake
  localparam int HOLD_CYCLES = 200;   // long receiver hold-off

  typedef struct packed {
    logic    sck;
    logic    mosi;
    logic    cs_int;
    logic    cs_ext;
    logic    cs_aux;
    logic    busy;
    status_t status;
    logic    done;
  } pin_tick_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] data
  logic [1:0]  in_tuser = '0;   // [0] start_req, [1] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [0] sck, [1] mosi, [2] cs_int, [3] cs_ext,
                                // [4] cs_aux, [5] busy_res, [7:6] start_status
  logic        out_tlast;       // done_res

  // frame sequencer mirror
  logic               pwr_on;
  logic               frm_active;
  logic               frm_int;
  logic [1:0]         frm_phase;
  logic [BIDX_W-1:0]  frm_bit;
  logic [SHIFT_W-1:0] frm_word;
  logic               pin_sck, pin_mosi, pin_cs_int, pin_cs_ext;

  pin_tick_t pending_ticks[$];
  int        err_cnt = 0;
  int        requests_sent = 0;
  int        ticks_seen = 0;
  int        frames_closed = 0;
  int        starts_refused = 0;
  int        stall_cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  serial_dac_frame_writer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void park_bus();
    frm_active = 1'b0;
    frm_int    = 1'b0;
    frm_phase  = 2'd0;
    frm_bit    = '0;
    pin_sck    = 1'b0;
    pin_mosi   = 1'b0;
    pin_cs_int = 1'b1;
    pin_cs_ext = 1'b1;
  endfunction

  // Advance the mirror by one tick and return the pin levels it reports.
  function automatic pin_tick_t next_pin_tick(logic start, logic fn, logic [15:0] val);
    pin_tick_t  t;
    int         nbits;
    logic [31:0] wide;
    t.status = ST_NONE;
    t.done   = 1'b0;
    if (frm_active) begin
      nbits = (frm_int == FUNC_INT) ? INT_FRAME_BITS : EXT_FRAME_BITS;
      if (int'(frm_bit) >= nbits) begin
        park_bus();
        t.done = 1'b1;
        frames_closed++;
      end else if (frm_phase == 2'd1) begin
        pin_mosi  = frm_word[nbits - 1 - int'(frm_bit)];
        frm_phase = 2'd2;
      end else if (frm_phase == 2'd2) begin
        pin_sck   = (frm_int == FUNC_INT);
        frm_phase = 2'd0;
        frm_bit   = frm_bit + 1'b1;
      end else begin
        pin_sck   = (frm_int != FUNC_INT);
        frm_phase = 2'd1;
      end
      if (start) t.status = pwr_on ? ST_BUSY : ST_OFF;
    end else if (start) begin
      if (!pwr_on) begin
        t.status = ST_OFF;
      end else begin
        t.status   = ST_ACCEPT;
        frm_active = 1'b1;
        frm_int    = fn;
        frm_phase  = 2'd0;
        frm_bit    = '0;
        if (fn == FUNC_INT) wide = {24'd0, val[7:0]};
        else wide = ({16'd0, val} << EXT_SHIFT) & EXT_WORD_MSK;
        frm_word   = wide[SHIFT_W-1:0];
        pin_sck    = 1'b0;
        pin_mosi   = 1'b0;
        pin_cs_int = (fn != FUNC_INT);
        pin_cs_ext = (fn == FUNC_INT);
      end
    end
    if (t.status == ST_OFF || t.status == ST_BUSY) starts_refused++;
    t.sck    = pin_sck;
    t.mosi   = pin_mosi;
    t.cs_int = pin_cs_int;
    t.cs_ext = pin_cs_ext;
    t.cs_aux = 1'b1;
    t.busy   = frm_active;
    return t;
  endfunction

  // Enter just after a rising edge, leave at the edge that takes the request.
  task automatic send_tick(logic start, logic fn, logic [15:0] val);
    int gap;
    gap = (!quiet && $urandom_range(99) < 12) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {fn, start};
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    pending_ticks.push_back(next_pin_tick(start, fn, val));
    requests_sent++;
  endtask

  task automatic send_plain_tick(logic start);
    send_tick(start, 1'($urandom_range(1)), 16'($urandom));
  endtask

  // Drop valid and wait until every expected tick has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic set_power(logic on);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    pwr_on = on;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_refused_when_off();
    set_power(1'b0);
    send_tick(1'b1, FUNC_EXT, 16'hFFFF);
    send_tick(1'b1, FUNC_INT, 16'h0000);
    send_tick(1'b0, FUNC_INT, 16'hFFFF);
    drain();
  endtask

  // Internal frame with a start while busy and one on the closing tick.
  task automatic test_internal_frame();
    set_power(1'b1);
    send_tick(1'b1, FUNC_INT, 16'hFFA5);
    for (int i = 1; i <= 25; i++) send_plain_tick(i == 5 || i == 25);
    send_tick(1'b0, FUNC_EXT, 16'h0000);
    drain();
  endtask

  // External frame of all-ones data; power drops mid-frame and the frame completes.
  task automatic test_power_drop_mid_frame();
    set_power(1'b1);
    send_tick(1'b1, FUNC_EXT, 16'hFFFF);
    for (int i = 1; i < 10; i++) send_plain_tick(1'b0);
    set_power(1'b0);
    for (int i = 10; i <= 74; i++) send_plain_tick(i % 20 == 0 || i == 73);
    send_tick(1'b1, FUNC_INT, 16'h00FF);
    drain();
  endtask

  // Mostly full frames with random content, sparse noise starts, power toggled
  // between stretches.
  task automatic test_random_frames(int total);
    int target;
    int stretch;
    target = requests_sent + total;
    while (requests_sent < target) begin
      set_power($urandom_range(99) < 85);
      stretch = $urandom_range(80, 250);
      repeat (stretch) begin
        if (frm_active) send_plain_tick($urandom_range(99) < 3);
        else send_plain_tick($urandom_range(99) < 50);
      end
    end
    drain();
  endtask

  task automatic test_back_to_back(int total);
    quiet = 1'b1;
    set_power(1'b1);
    repeat (total) send_plain_tick(frm_active ? ($urandom_range(99) < 2) : 1'b1);
    drain();
    quiet = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    set_power(1'b1);
    hold_req = 1'b1;
    repeat (80) send_plain_tick(!frm_active);
    drain();
  endtask

  initial begin
    pwr_on = 1'b0;
    frm_word = '0;
    park_bus();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_refused_when_off();
    test_internal_frame();
    test_power_drop_mid_frame();
    test_output_backpressure();
    test_random_frames(1200);
    test_back_to_back(250);
    repeat (8) @(posedge clk);
    $display("covered %0d requests, %0d ticks checked, %0d frames closed, %0d starts refused",
             requests_sent, ticks_seen, frames_closed, starts_refused);
    if (err_cnt == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (quiet) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(99) >= 12);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pin_tick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      ticks_seen++;
      if (pending_ticks.size() == 0) begin
        $error("result with no pending request: tdata %02h tlast %0d", out_tdata, out_tlast);
        err_cnt++;
      end else begin
        want = pending_ticks.pop_front();
        check_field("sck", want.sck, out_tdata[0]);
        check_field("mosi", want.mosi, out_tdata[1]);
        check_field("cs_int", want.cs_int, out_tdata[2]);
        check_field("cs_ext", want.cs_ext, out_tdata[3]);
        check_field("cs_aux", want.cs_aux, out_tdata[4]);
        check_field("busy_res", want.busy, out_tdata[5]);
        check_field("start_status", want.status, out_tdata[7:6]);
        check_field("done_res", want.done, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

endmodule

### sim.f
design/sdfw_pkg.sv
design/sdfw_core.sv
design/sdfw_out_reg.sv
design/serial_dac_frame_writer_top.sv
design/sdfw_checker.sv
tb/testbench.sv
